// ----- rtl/core/uvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvc_pkg: shared types and constants of the varint codec
// Word layouts of both channels, the queued operation word, command and
// result kind codes, and the 7-bit group constants.
// ----------------------------------------------------------------------------
package uvc_pkg;

    localparam int unsigned GROUP_BITS  = 7;
    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned GROUP_W     = 4;
    localparam int unsigned GROUP_LIMIT = 10;
    localparam int unsigned ENC_W       = VALUE_W - GROUP_BITS;

    localparam logic [GROUP_BITS-1:0] GROUP_MASK = '1;
    localparam logic [BYTE_W-1:0]     CONT_FLAG  = BYTE_W'(1 << GROUP_BITS);

    // command codes
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    typedef struct packed {
        logic               command;
        logic [VALUE_W-1:0] value_in;
        logic [BYTE_W-1:0]  byte_in;
        logic               end_of_buffer;
    } req_word_t;

    typedef struct packed {
        logic               result_kind;
        logic [BYTE_W-1:0]  byte_out;
        logic [VALUE_W-1:0] value_out;
        logic               last;
        logic               overflow;
    } rsp_word_t;

    // classified operation as it waits in the queue
    typedef struct packed {
        logic                  command;
        logic [VALUE_W-1:0]    value;
        logic [GROUP_W-1:0]    nbytes;
        logic [GROUP_BITS-1:0] payload;
        logic                  done;
    } op_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        op_t  op;
    } head_t;

endpackage

// ----- rtl/core/uvc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvc_front: request classifier
// Turns a request word into an operation: byte count for encode, payload and
// end-of-value flag for decode.
// ----------------------------------------------------------------------------
module uvc_front (
    input  uvc_pkg::req_word_t req_data,
    output uvc_pkg::op_t       op
);
    import uvc_pkg::*;

    localparam int unsigned HI_N = GROUP_LIMIT - 1;

    logic [HI_N-1:0] hi_nz;

    // group k present when anything sits at or above bit 7k
    always_comb
    begin
        for (int k = 1; k <= HI_N; k++)
        begin
            hi_nz[k-1] = |(req_data.value_in >> (GROUP_BITS * k));
        end
    end

    always_comb
    begin
        op.command = req_data.command;
        op.value   = req_data.value_in;
        op.nbytes  = GROUP_W'(1) + GROUP_W'($countones(hi_nz));
        op.payload = req_data.byte_in[GROUP_BITS-1:0];
        op.done    = ((req_data.byte_in & CONT_FLAG) == '0) || req_data.end_of_buffer;
    end

endmodule

// ----- rtl/core/uvc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvc_queue: two-entry operation queue
// Decouples request acceptance from the back end sequencer.
// ----------------------------------------------------------------------------
module uvc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  uvc_pkg::op_t  push_op,
    output logic          full,
    input  logic          pop,
    output uvc_pkg::head_t head
);
    import uvc_pkg::*;

    op_t        entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full     = (count_reg == 2'd2);
    assign do_push  = push && !full;
    assign do_pop   = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.op    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ----- rtl/core/uvc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvc_back: encode sequencer and decode accumulator
// Emits one encoded byte per cycle when not stalled, folds decode bytes into
// the accumulator, and holds the response word in an output register.
// ----------------------------------------------------------------------------
module uvc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  uvc_pkg::head_t     head,
    output logic               pop,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output uvc_pkg::rsp_word_t rsp_data
);
    import uvc_pkg::*;

    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_word_t              rsp_data_reg, rsp_data_next;
    logic [ENC_W-1:0]       enc_val_reg, enc_val_next;
    logic [GROUP_W-1:0]     enc_left_reg, enc_left_next;
    logic [VALUE_W-1:0]     acc_reg, acc_next;
    logic [GROUP_W-1:0]     group_reg, group_next;
    logic                   ovf_reg, ovf_next;

    logic                   load_ok;
    logic [VALUE_W-1:0]     acc_upd;
    logic [GROUP_W-1:0]     group_upd;
    logic                   ovf_upd;
    logic [GROUP_BITS-1:0]  pl;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;
    assign load_ok   = !rsp_valid_reg || !rsp_stall;
    assign pl        = head.op.payload;

    // place the payload at its group, group nine keeps only bit 63
    always_comb
    begin
        acc_upd   = acc_reg;
        group_upd = group_reg;
        ovf_upd   = ovf_reg;
        for (int k = 0; k < GROUP_LIMIT - 1; k++)
        begin
            if (group_reg == GROUP_W'(k))
            begin
                acc_upd[GROUP_BITS*k +: GROUP_BITS] =
                    acc_reg[GROUP_BITS*k +: GROUP_BITS] | pl;
            end
        end
        if (group_reg == GROUP_W'(GROUP_LIMIT - 1))
        begin
            acc_upd[VALUE_W-1] = acc_reg[VALUE_W-1] | pl[0];
            if (pl[GROUP_BITS-1:1] != '0)
            begin
                ovf_upd = 1'b1;
            end
        end
        if (group_reg < GROUP_W'(GROUP_LIMIT))
        begin
            group_upd = group_reg + GROUP_W'(1);
        end
        else if (pl != '0)
        begin
            ovf_upd = 1'b1;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        enc_val_next   = enc_val_reg;
        enc_left_next  = enc_left_reg;
        acc_next       = acc_reg;
        group_next     = group_reg;
        ovf_next       = ovf_reg;
        pop            = 1'b0;
        if (load_ok)
        begin
            rsp_valid_next = 1'b0;
            if (enc_left_reg != '0)
            begin
                // remaining bytes of an encode
                rsp_valid_next            = 1'b1;
                rsp_data_next.result_kind = KIND_BYTE;
                rsp_data_next.byte_out    = {enc_left_reg > GROUP_W'(1),
                                             enc_val_reg[GROUP_BITS-1:0]};
                rsp_data_next.value_out   = '0;
                rsp_data_next.last        = (enc_left_reg == GROUP_W'(1));
                rsp_data_next.overflow    = 1'b0;
                enc_val_next              = enc_val_reg >> GROUP_BITS;
                enc_left_next             = enc_left_reg - GROUP_W'(1);
            end
            else if (head.valid)
            begin
                pop = 1'b1;
                if (head.op.command == CMD_ENCODE)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_data_next.result_kind = KIND_BYTE;
                    rsp_data_next.byte_out    = {head.op.nbytes > GROUP_W'(1),
                                                 head.op.value[GROUP_BITS-1:0]};
                    rsp_data_next.value_out   = '0;
                    rsp_data_next.last        = (head.op.nbytes == GROUP_W'(1));
                    rsp_data_next.overflow    = 1'b0;
                    enc_val_next              = head.op.value[VALUE_W-1:GROUP_BITS];
                    enc_left_next             = head.op.nbytes - GROUP_W'(1);
                end
                else if (head.op.done)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_data_next.result_kind = KIND_VALUE;
                    rsp_data_next.byte_out    = '0;
                    rsp_data_next.value_out   = acc_upd;
                    rsp_data_next.last        = 1'b1;
                    rsp_data_next.overflow    = ovf_upd;
                    acc_next                  = '0;
                    group_next                = '0;
                    ovf_next                  = 1'b0;
                end
                else
                begin
                    acc_next   = acc_upd;
                    group_next = group_upd;
                    ovf_next   = ovf_upd;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            enc_left_reg  <= '0;
            acc_reg       <= '0;
            group_reg     <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            enc_left_reg  <= enc_left_next;
            acc_reg       <= acc_next;
            group_reg     <= group_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
        enc_val_reg  <= enc_val_next;
    end

`ifndef SYNTH
    a_enc_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        enc_left_reg <= GROUP_W'(GROUP_LIMIT - 1))
        else $error("encode byte count out of range");

    a_group_sat: assert property (@(posedge clk) disable iff (!rst_n)
        group_reg <= GROUP_W'(GROUP_LIMIT))
        else $error("group count beyond limit");

    a_no_pop_mid_encode: assert property (@(posedge clk) disable iff (!rst_n)
        (enc_left_reg != '0) |-> !pop)
        else $error("queue popped while encode bytes remain");
`endif

endmodule

// ----- rtl/core/unsigned_varint_codec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_varint_codec: unsigned LEB128 varint encoder and decoder
// Front classifier, two-entry queue and back end sequencer with a registered
// response word.
// ----------------------------------------------------------------------------
// Each request word carries one command. Encode turns value_in into one to ten
// response bytes, low 7-bit group first, bit 7 set on all but the final byte;
// the back end emits one byte per cycle while the response is not stalled
// and pops no operation until an encode's bytes are out. Decode likewise takes
// one byte per cycle and folds its payload into an accumulator; a value word
// comes out when the byte has bit 7 clear or end_of_buffer set, with overflow
// flagging dropped nonzero bits past bit 63. A decode byte that only continues
// a value gives no response. Encodes interleaved with a decode leave the
// partial value untouched. The two-entry queue lets requests keep arriving
// while the response register is stalled.
// ----------------------------------------------------------------------------
module unsigned_varint_codec (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  uvc_pkg::req_word_t req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output uvc_pkg::rsp_word_t rsp_data
);
    import uvc_pkg::*;

    op_t   front_op;
    head_t head;
    logic  queue_full;
    logic  pop;

    // classify the incoming word
    uvc_front u_front (
        .req_data (req_data),
        .op       (front_op)
    );

    // the queue's full flag is the request stall
    assign req_stall = queue_full;

    uvc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (req_valid),
        .push_op (front_op),
        .full    (queue_full),
        .pop     (pop),
        .head    (head)
    );

    // encode sequencing, decode accumulation, response register
    uvc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule
